[hdl/uvsph_pkg.sv]
// Shared constants, types and fixed-point helpers for the UV sphere vertex generator.
`default_nettype none

package uvsph_pkg;

	localparam int MAX_DIV = 255;
	localparam int ANG_F = 16;

	// reciprocal scale for division by a grid count; exact for numerators below 2^(S-8)
	localparam int RECIP_S = ((ANG_F > 16) ? ANG_F : 16) + 16;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [30:0] Q30_HALF = 31'h2000_0000;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	// register indexes
	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_SLICES = 2'd1;
	localparam logic [1:0] REG_STACKS = 2'd2;

	// trig unit spans pipeline stages 3 to 14
	localparam int TRIG_STAGES = 12;

	// floor(x / d) for x < 2^30 as (x * M) >> S, M = ceil(2^S / d), S = 30 + ceil(log2 d)
	localparam int DS72 = 37;
	localparam int DS42 = 36;
	localparam int DS20 = 35;
	localparam int DS6 = 33;
	localparam int DS90 = 37;
	localparam int DS56 = 36;
	localparam int DS30 = 35;
	localparam int DS12 = 34;
	localparam logic [31:0] DM72 = 32'(((64'd1 << DS72) + 64'd71) / 64'd72);
	localparam logic [31:0] DM42 = 32'(((64'd1 << DS42) + 64'd41) / 64'd42);
	localparam logic [31:0] DM20 = 32'(((64'd1 << DS20) + 64'd19) / 64'd20);
	localparam logic [31:0] DM6 = 32'(((64'd1 << DS6) + 64'd5) / 64'd6);
	localparam logic [31:0] DM90 = 32'(((64'd1 << DS90) + 64'd89) / 64'd90);
	localparam logic [31:0] DM56 = 32'(((64'd1 << DS56) + 64'd55) / 64'd56);
	localparam logic [31:0] DM30 = 32'(((64'd1 << DS30) + 64'd29) / 64'd30);
	localparam logic [31:0] DM12 = 32'(((64'd1 << DS12) + 64'd11) / 64'd12);

	// sign-magnitude Q2.30
	typedef struct packed {
		logic        neg;
		logic [30:0] mag;
	} sval_t;

	// truncating Q2.30 product
	function automatic logic [30:0] qmul(logic [30:0] x, logic [30:0] y);
		logic [63:0] p;
		p = 64'(x) * 64'(y);
		return p[60:30];
	endfunction

	function automatic logic [29:0] cdiv(logic [29:0] x, logic [31:0] m, int s);
		logic [63:0] p;
		p = 64'(x) * 64'(m);
		p = p >> s;
		return p[29:0];
	endfunction

	// rounded product of two sign-magnitude values
	function automatic sval_t smul(sval_t a, sval_t b);
		logic [63:0] p;
		sval_t r;
		p = 64'(a.mag) * 64'(b.mag) + 64'(Q30_HALF);
		r.mag = p[60:30];
		r.neg = a.neg ^ b.neg;
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/uvsph_trig.sv]
// Pipelined sine and cosine of a 32-bit turn phase, twelve register stages.
`default_nettype none

module uvsph_trig (
	input  logic                                 clk,
	input  logic [uvsph_pkg::TRIG_STAGES-1:0]    en,
	input  logic [31:0]                          phase,
	output uvsph_pkg::sval_t                     sin_val,
	output uvsph_pkg::sval_t                     cos_val
);
	import uvsph_pkg::*;

	logic [1:0]  quad_s [3:13];
	logic        swap_s [3:13];
	logic [29:0] t_s3;
	logic [29:0] a_s [4:12];
	logic [29:0] a2_s [5:12];
	logic [30:0] hs_s6, hc_s6, hs_s8, hc_s8, hs_s10, hc_s10, hs_s12, hc_s12;
	logic [30:0] ps_s7, pc_s7, ps_s9, pc_s9, ps_s11, pc_s11;
	logic [30:0] s_s13, pc_s13;
	sval_t       sin_s14, cos_s14;

	logic [29:0] r_in;
	logic [63:0] ang_prod;
	logic [30:0] c_full;
	logic [30:0] ts, tc;

	assign r_in = phase[29:0];
	assign ang_prod = 64'(t_s3) * 64'(PI_Q30);
	assign c_full = Q30_ONE - {1'b0, pc_s13[30:1]};
	assign ts = swap_s[13] ? c_full : s_s13;
	assign tc = swap_s[13] ? s_s13 : c_full;

	always_ff @(posedge clk) begin
		// octant fold
		if (en[0]) begin
			quad_s[3] <= phase[31:30];
			if (r_in > Q30_HALF[29:0]) begin
				t_s3 <= Q30_ONE[29:0] - r_in;
				swap_s[3] <= 1'b1;
			end else begin
				t_s3 <= r_in;
				swap_s[3] <= 1'b0;
			end
		end
		for (int k = 4; k <= 13; k++) begin
			if (en[k-3]) begin
				quad_s[k] <= quad_s[k-1];
				swap_s[k] <= swap_s[k-1];
			end
		end
		if (en[1]) a_s[4] <= ang_prod[60:31];
		for (int k = 5; k <= 12; k++) begin
			if (en[k-3]) a_s[k] <= a_s[k-1];
		end
		if (en[2]) a2_s[5] <= 30'(qmul({1'b0, a_s[4]}, {1'b0, a_s[4]}));
		for (int k = 6; k <= 12; k++) begin
			if (en[k-3]) a2_s[k] <= a2_s[k-1];
		end
		// Horner steps, sine chain and cosine chain side by side
		if (en[3]) begin
			hs_s6 <= Q30_ONE - {1'b0, cdiv(a2_s[5], DM72, DS72)};
			hc_s6 <= Q30_ONE - {1'b0, cdiv(a2_s[5], DM90, DS90)};
		end
		if (en[4]) begin
			ps_s7 <= qmul({1'b0, a2_s[6]}, hs_s6);
			pc_s7 <= qmul({1'b0, a2_s[6]}, hc_s6);
		end
		if (en[5]) begin
			hs_s8 <= Q30_ONE - {1'b0, cdiv(ps_s7[29:0], DM42, DS42)};
			hc_s8 <= Q30_ONE - {1'b0, cdiv(pc_s7[29:0], DM56, DS56)};
		end
		if (en[6]) begin
			ps_s9 <= qmul({1'b0, a2_s[8]}, hs_s8);
			pc_s9 <= qmul({1'b0, a2_s[8]}, hc_s8);
		end
		if (en[7]) begin
			hs_s10 <= Q30_ONE - {1'b0, cdiv(ps_s9[29:0], DM20, DS20)};
			hc_s10 <= Q30_ONE - {1'b0, cdiv(pc_s9[29:0], DM30, DS30)};
		end
		if (en[8]) begin
			ps_s11 <= qmul({1'b0, a2_s[10]}, hs_s10);
			pc_s11 <= qmul({1'b0, a2_s[10]}, hc_s10);
		end
		if (en[9]) begin
			hs_s12 <= Q30_ONE - {1'b0, cdiv(ps_s11[29:0], DM6, DS6)};
			hc_s12 <= Q30_ONE - {1'b0, cdiv(pc_s11[29:0], DM12, DS12)};
		end
		if (en[10]) begin
			s_s13 <= qmul({1'b0, a_s[12]}, hs_s12);
			pc_s13 <= qmul({1'b0, a2_s[12]}, hc_s12);
		end
		// unfold to the full turn
		if (en[11]) begin
			case (quad_s[13])
				2'd0: begin
					sin_s14 <= '{neg: 1'b0, mag: ts};
					cos_s14 <= '{neg: 1'b0, mag: tc};
				end
				2'd1: begin
					sin_s14 <= '{neg: 1'b0, mag: tc};
					cos_s14 <= '{neg: 1'b1, mag: ts};
				end
				2'd2: begin
					sin_s14 <= '{neg: 1'b1, mag: ts};
					cos_s14 <= '{neg: 1'b1, mag: tc};
				end
				default: begin
					sin_s14 <= '{neg: 1'b1, mag: tc};
					cos_s14 <= '{neg: 1'b0, mag: ts};
				end
			endcase
		end
	end

	assign sin_val = sin_s14;
	assign cos_val = cos_s14;

endmodule

`default_nettype wire

[hdl/uv_sphere_vertex_generator.sv]
// UV sphere vertex generator: one grid point in, one vertex word out.
//
// Input channel (in_valid/in_ready) takes a grid point (stack_index,
// slice_index); output channel (out_valid/out_ready) gives the vertex
// position, texture coordinates and, for points that open a quad, the six
// triangle corner indices. Indices above the configured counts are clamped.
// Configuration is a write port (cfg_we, cfg_index, cfg_data), written
// while no word is in flight; it takes effect for words accepted after it.
// Throughput: one word per cycle; a new word is accepted every cycle the
// pipeline can shift. The pipeline depth is set by the sine/cosine Horner
// chain, one multiplier per stage. A stall on out_ready holds the output
// word; earlier stages keep moving into empty slots, so bubbles close up
// and in_ready only drops once every stage holds a word. Nothing is lost
// or repeated. Reset (arst_n low) empties the pipeline and loads radius
// 1.0 and 16 slices by 16 stacks.
`default_nettype none

module uv_sphere_vertex_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         stack_index,
	input  logic [7:0]         slice_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [24:0] pos_x,
	output logic signed [24:0] pos_y,
	output logic signed [24:0] pos_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic               has_triangles,
	output logic [15:0]        first_corner_a,
	output logic [15:0]        first_corner_b,
	output logic [15:0]        first_corner_c,
	output logic [15:0]        second_corner_a,
	output logic [15:0]        second_corner_b,
	output logic [15:0]        second_corner_c
);
	import uvsph_pkg::*;

	localparam int NSTG = 16;
	localparam int ANG_NW = 8 + ANG_F;
	localparam int PROD_W = ANG_NW + RECIP_S + 1;

	typedef struct packed {
		logic [16:0] tu;
		logic [16:0] tv;
		logic        has;
		logic [15:0] c0;
		logic [15:0] c1;
		logic [15:0] c2;
		logic [15:0] c3;
	} side_t;

	logic [23:0] radius_q;
	logic [7:0]  slice_cnt_q, stack_cnt_q;
	logic [7:0]  slices, stacks;
	logic [RECIP_S:0] recip_tab [256];
	logic [RECIP_S:0] recip_sl_q, recip_st_q;

	logic [NSTG:1]   v_q;
	logic [NSTG:1]   v_prev;
	logic [NSTG+1:1] en;

	logic [7:0]  st_s1, sl_s1;
	logic [31:0] ph_lon_s2, ph_lat_s2;
	side_t       side_s [2:NSTG];
	sval_t       slon, clon, slat, clat;
	sval_t       mx_s15, mz_s15, my_s15;
	logic signed [24:0] pos_x_s16, pos_y_s16, pos_z_s16;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 24'd65536;
			slice_cnt_q <= 8'd16;
			stack_cnt_q <= 8'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data;
				REG_SLICES: slice_cnt_q <= cfg_data[7:0];
				REG_STACKS: stack_cnt_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		slices = (slice_cnt_q == 8'd0) ? 8'd1 : slice_cnt_q;
		stacks = (stack_cnt_q == 8'd0) ? 8'd1 : stack_cnt_q;
		if (32'(slices) > MAX_DIV) slices = 8'(MAX_DIV);
		if (32'(stacks) > MAX_DIV) stacks = 8'(MAX_DIV);
	end

	// reciprocal table, ceil(2^S / d)
	assign recip_tab[0] = '0;
	for (genvar d = 1; d < 256; d++) begin : g_recip
		localparam logic [RECIP_S:0] RV =
			(RECIP_S+1)'(((64'd1 << RECIP_S) + 64'(d) - 64'd1) / 64'(d));
		assign recip_tab[d] = RV;
	end

	// follows the count registers, settles in the cycle after a write
	always_ff @(posedge clk) begin
		recip_sl_q <= recip_tab[slices];
		recip_st_q <= recip_tab[stacks];
	end

	// stall chain: a stage loads when empty or when the next one loads
	always_comb begin
		en[NSTG+1] = out_ready;
		for (int k = NSTG; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign v_prev = {v_q[NSTG-1:1], in_valid};
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (en[k]) v_q[k] <= v_prev[k];
			end
		end
	end

	// stage 1: clamp
	always_ff @(posedge clk) begin
		if (en[1]) begin
			st_s1 <= (stack_index > stacks) ? stacks : stack_index;
			sl_s1 <= (slice_index > slices) ? slices : slice_index;
		end
	end

	// stage 2: phases, texture coordinates and quad corners
	logic [PROD_W-1:0] p_lon, p_lat, p_tu, p_tv;
	logic [ANG_F:0]    q_lon;
	logic [ANG_F+1:0]  q_lat;
	logic [8:0]        cols;
	logic [16:0]       a_idx;
	logic              has;
	side_t             side_d;

	always_comb begin
		p_lon = PROD_W'({sl_s1, {ANG_F{1'b0}}} + ANG_NW'(slices >> 1)) * PROD_W'(recip_sl_q);
		p_lat = PROD_W'({st_s1, {ANG_F{1'b0}}} + ANG_NW'(stacks)) * PROD_W'(recip_st_q);
		p_tu = PROD_W'({sl_s1, 16'b0} + 24'(slices >> 1)) * PROD_W'(recip_sl_q);
		p_tv = PROD_W'({st_s1, 16'b0} + 24'(stacks >> 1)) * PROD_W'(recip_st_q);
		q_lon = p_lon[RECIP_S +: ANG_F+1];
		q_lat = p_lat[RECIP_S +: ANG_F+2];
		cols = 9'(slices) + 9'd1;
		a_idx = 17'(st_s1) * 17'(cols) + 17'(sl_s1);
		has = (st_s1 < stacks) && (sl_s1 < slices);
		side_d.tu = p_tu[RECIP_S +: 17];
		side_d.tv = p_tv[RECIP_S +: 17];
		side_d.has = has;
		side_d.c0 = has ? a_idx[15:0] : 16'd0;
		side_d.c1 = has ? 16'(a_idx + 17'd1) : 16'd0;
		side_d.c2 = has ? 16'(a_idx + 17'(cols)) : 16'd0;
		side_d.c3 = has ? 16'(a_idx + 17'(cols) + 17'd1) : 16'd0;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ph_lon_s2 <= {q_lon[ANG_F-1:0], {(32-ANG_F){1'b0}}};
			// latitude divides by twice the stack count
			ph_lat_s2 <= {q_lat[ANG_F:1], {(32-ANG_F){1'b0}}};
			side_s[2] <= side_d;
		end
		for (int k = 3; k <= NSTG; k++) begin
			if (en[k]) side_s[k] <= side_s[k-1];
		end
	end

	// stages 3 to 14
	uvsph_trig u_trig_lon (
		.clk     (clk),
		.en      (en[14:3]),
		.phase   (ph_lon_s2),
		.sin_val (slon),
		.cos_val (clon)
	);

	uvsph_trig u_trig_lat (
		.clk     (clk),
		.en      (en[14:3]),
		.phase   (ph_lat_s2),
		.sin_val (slat),
		.cos_val (clat)
	);

	// stage 15: direction products; y points down at the first stack
	always_ff @(posedge clk) begin
		if (en[15]) begin
			mx_s15 <= smul(slat, clon);
			mz_s15 <= smul(slat, slon);
			my_s15 <= '{neg: !clat.neg, mag: clat.mag};
		end
	end

	// stage 16: scale by radius
	function automatic logic signed [24:0] scale(logic [23:0] r, sval_t m);
		logic [63:0] p;
		logic [24:0] mag;
		p = 64'(r) * 64'(m.mag) + 64'(Q30_HALF);
		mag = p[54:30];
		return m.neg ? (25'd0 - mag) : mag;
	endfunction

	always_ff @(posedge clk) begin
		if (en[16]) begin
			pos_x_s16 <= scale(radius_q, mx_s15);
			pos_y_s16 <= scale(radius_q, my_s15);
			pos_z_s16 <= scale(radius_q, mz_s15);
		end
	end

	assign out_valid = v_q[NSTG];
	assign pos_x = pos_x_s16;
	assign pos_y = pos_y_s16;
	assign pos_z = pos_z_s16;
	assign tex_u = side_s[NSTG].tu;
	assign tex_v = side_s[NSTG].tv;
	assign has_triangles = side_s[NSTG].has;
	assign first_corner_a = side_s[NSTG].c0;
	assign first_corner_b = side_s[NSTG].c1;
	assign first_corner_c = side_s[NSTG].c2;
	assign second_corner_a = side_s[NSTG].c2;
	assign second_corner_b = side_s[NSTG].c1;
	assign second_corner_c = side_s[NSTG].c3;

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_q[1])
		else $error("accepted word did not reach stage 1");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NSTG-1] && !en[NSTG] |=> v_q[NSTG-1] && v_q[NSTG])
		else $error("stalled stage lost its word");

	a_no_quad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_triangles |-> first_corner_a == 16'd0 &&
		first_corner_b == 16'd0 && first_corner_c == 16'd0 &&
		second_corner_c == 16'd0)
		else $error("corner indices set without a quad");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tex_u <= 17'd65536 && tex_v <= 17'd65536)
		else $error("texture coordinate above one");

endmodule

`default_nettype wire

[sim/uv_sphere_vertex_generator_tb.sv]
// Self-checking UV sphere vertex generator testbench: directed and random grid points over several register settings.
`timescale 1ns / 100ps

module uv_sphere_vertex_generator_tb;
	import uvsph_pkg::*;

	typedef struct packed {
		logic [7:0] st;
		logic [7:0] sl;
	} point_t;

	typedef struct packed {
		logic [24:0] x;
		logic [24:0] y;
		logic [24:0] z;
		logic [16:0] u;
		logic [16:0] v;
		logic        tri_ok;
		logic [15:0] f_a, f_b, f_c, s_a, s_b, s_c;
	} vertex_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [63:0] ONE30 = 64'd1 << 30;
	localparam logic [63:0] HALF30 = 64'd1 << 29;

	logic clk, arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [23:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [7:0] stack_index, slice_index;
	logic signed [24:0] pos_x, pos_y, pos_z;
	logic [16:0] tex_u, tex_v;
	logic has_triangles;
	logic [15:0] first_corner_a, first_corner_b, first_corner_c;
	logic [15:0] second_corner_a, second_corner_b, second_corner_c;

	uv_sphere_vertex_generator dut (.*);

	// register copies
	logic [23:0] radius_q;
	logic [7:0] slices_q, stacks_q;

	point_t points_q[$];
	vertex_t vertices_q[$];
	int errors, cycles, in_gap, out_gap;
	int hold_until;
	bit quiet, in_acc;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] eff(logic [7:0] c);
		if (c == 0) return 1;
		if (c > MAX_DIV) return MAX_DIV;
		return 64'(c);
	endfunction

	function automatic logic [63:0] qm(logic [63:0] a, logic [63:0] b);
		return (a * b) >> 30;
	endfunction

	function automatic logic [63:0] turn_phase(logic [63:0] idx, logic [63:0] div);
		logic [63:0] p;
		p = ((idx << ANG_F) + div / 2) / div;
		return (p << (32 - ANG_F)) & 64'hFFFF_FFFF;
	endfunction

	// sine and cosine as sign-magnitude Q2.30
	function automatic void sin_cos(input logic [63:0] ph, output logic [63:0] sm,
			output bit sn, output logic [63:0] cm, output bit cn);
		logic [63:0] r, t, a, a2, h, s, c, ts, tc;
		logic [1:0] quad;
		quad = ph[31:30];
		r = ph & (ONE30 - 1);
		t = (r > HALF30) ? ONE30 - r : r;
		a = (t * 64'(PI_Q30)) >> 31;
		a2 = qm(a, a);
		h = ONE30 - a2 / 72;
		h = ONE30 - qm(a2, h) / 42;
		h = ONE30 - qm(a2, h) / 20;
		h = ONE30 - qm(a2, h) / 6;
		s = qm(a, h);
		h = ONE30 - a2 / 90;
		h = ONE30 - qm(a2, h) / 56;
		h = ONE30 - qm(a2, h) / 30;
		h = ONE30 - qm(a2, h) / 12;
		c = ONE30 - qm(a2, h) / 2;
		if (r > HALF30) begin
			ts = c; tc = s;
		end else begin
			ts = s; tc = c;
		end
		case (quad)
			2'd0: begin sm = ts; sn = 0; cm = tc; cn = 0; end
			2'd1: begin sm = tc; sn = 0; cm = ts; cn = 1; end
			2'd2: begin sm = ts; sn = 1; cm = tc; cn = 1; end
			default: begin sm = tc; sn = 1; cm = ts; cn = 0; end
		endcase
	endfunction

	function automatic logic [24:0] scaled(logic [63:0] m, bit n);
		logic [63:0] p;
		p = (64'(radius_q) * m + HALF30) >> 30;
		return n ? 25'(64'd0 - p) : 25'(p);
	endfunction

	function automatic vertex_t vertex_of(point_t pt);
		vertex_t e;
		logic [63:0] sl_n, st_n, sl, st, slm, clm, sbm, cbm, cols, a;
		bit sln, cln, sbn, cbn;
		sl_n = eff(slices_q);
		st_n = eff(stacks_q);
		sl = (pt.sl > sl_n) ? sl_n : 64'(pt.sl);
		st = (pt.st > st_n) ? st_n : 64'(pt.st);
		sin_cos(turn_phase(sl, sl_n), slm, sln, clm, cln);
		sin_cos(turn_phase(st, 2 * st_n), sbm, sbn, cbm, cbn);
		e = '0;
		e.x = scaled((sbm * clm + HALF30) >> 30, sbn ^ cln);
		e.y = scaled(cbm, !cbn);
		e.z = scaled((sbm * slm + HALF30) >> 30, sbn ^ sln);
		e.u = 17'((sl * 65536 + sl_n / 2) / sl_n);
		e.v = 17'((st * 65536 + st_n / 2) / st_n);
		if (st < st_n && sl < sl_n) begin
			cols = sl_n + 1;
			a = st * cols + sl;
			e.tri_ok = 1;
			e.f_a = 16'(a);
			e.f_b = 16'(a + 1);
			e.f_c = 16'(a + cols);
			e.s_a = 16'(a + cols);
			e.s_b = 16'(a + 1);
			e.s_c = 16'(a + cols + 1);
		end
		return e;
	endfunction

	// input side: hold the word until accepted, idle in bursts
	always @(negedge clk or negedge arst_n) begin
		logic v;
		if (!arst_n) begin
			in_valid <= 0;
			stack_index <= 0;
			slice_index <= 0;
			in_gap = 0;
		end else if (!in_valid || in_acc) begin
			v = 0;
			if (in_gap > 0)
				in_gap--;
			else if (!quiet && $urandom_range(0, 9) == 0)
				in_gap = $urandom_range(0, 16);
			else if (points_q.size() > 0) begin
				v = 1;
				{stack_index, slice_index} <= points_q.pop_front();
			end
			in_valid <= v;
		end
	end

	// output side: random stall bursts plus one long hold-off
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			out_gap = 0;
		end else if (cycles < hold_until)
			out_ready <= 0;
		else if (out_gap > 0) begin
			out_gap--;
			out_ready <= 0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_gap = $urandom_range(0, 16);
			out_ready <= 0;
		end else
			out_ready <= 1;
	end

	always @(posedge clk) begin
		vertex_t got, want;
		cycles++;
		in_acc = arst_n && in_valid && in_ready;
		if (in_acc)
			vertices_q.push_back(vertex_of({stack_index, slice_index}));
		if (arst_n && out_valid && out_ready) begin
			got = {pos_x, pos_y, pos_z, tex_u, tex_v, has_triangles, first_corner_a,
				first_corner_b, first_corner_c, second_corner_a, second_corner_b,
				second_corner_c};
			if (vertices_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word %h", got);
			end else begin
				want = vertices_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: xyz exp %h %h %h got %h %h %h; uv exp %h %h got %h %h; tri exp %b %h %h %h %h %h %h got %b %h %h %h %h %h %h",
							want.x, want.y, want.z, got.x, got.y, got.z,
							want.u, want.v, got.u, got.v,
							want.tri_ok, want.f_a, want.f_b, want.f_c, want.s_a, want.s_b, want.s_c,
							got.tri_ok, got.f_a, got.f_b, got.f_c, got.s_a, got.s_b, got.s_c);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("uv_sphere_vertex_generator_tb NOT OK");
			$finish;
		end
	end

	// sampled at the rising edge, where the driven inputs are settled
	task automatic drain();
		do
			@(posedge clk);
		while (points_q.size() != 0 || in_valid || vertices_q.size() != 0);
		repeat (24) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_RADIUS: radius_q = val;
			REG_SLICES: slices_q = val[7:0];
			REG_STACKS: stacks_q = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic add_random(int n);
		point_t p;
		int lim_sl, lim_st;
		lim_sl = int'(eff(slices_q)) + 2;
		lim_st = int'(eff(stacks_q)) + 2;
		repeat (n) begin
			if ($urandom_range(0, 4) == 0) begin
				p.st = 8'($urandom);
				p.sl = 8'($urandom);
			end else begin
				p.st = 8'($urandom_range(0, lim_st > 255 ? 255 : lim_st));
				p.sl = 8'($urandom_range(0, lim_sl > 255 ? 255 : lim_sl));
			end
			points_q.push_back(p);
		end
	endtask

	initial begin
		logic [23:0] rad_set[7] = '{24'd65536, 24'hFFFFFF, 24'd0, 24'd65536, 24'd1, 24'd0, 24'd0};
		logic [7:0] sl_set[7] = '{8'd16, 8'd1, 8'd255, 8'd0, 8'd3, 8'd0, 8'd0};
		logic [7:0] st_set[7] = '{8'd16, 8'd1, 8'd255, 8'd0, 8'd7, 8'd0, 8'd0};
		errors = 0;
		cycles = 0;
		hold_until = 0;
		quiet = 0;
		in_acc = 0;
		cfg_we = 0;
		cfg_index = REG_RADIUS;
		cfg_data = 0;
		radius_q = 24'd65536;
		slices_q = 8'd16;
		stacks_q = 8'd16;
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// poles, equator, quadrant edges, clamping and the last row and column
		points_q = '{'{8'd0, 8'd0}, '{8'd16, 8'd16}, '{8'd255, 8'd255}, '{8'd8, 8'd0},
			'{8'd8, 8'd4}, '{8'd8, 8'd8}, '{8'd8, 8'd12}, '{8'd0, 8'd16}, '{8'd16, 8'd0},
			'{8'd15, 8'd15}, '{8'd17, 8'd3}, '{8'd3, 8'd17}, '{8'd4, 8'd2}, '{8'd12, 8'd6},
			'{8'd170, 8'd85}, '{8'd85, 8'd170}, '{8'd1, 8'd1}};
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0) begin
				rad_set[5] = 24'($urandom);
				sl_set[5] = 8'($urandom_range(1, 40));
				st_set[5] = 8'($urandom_range(1, 40));
				rad_set[6] = 24'($urandom);
				sl_set[6] = 8'($urandom);
				st_set[6] = 8'($urandom);
				write_reg(REG_RADIUS, rad_set[ph]);
				write_reg(REG_SLICES, sl_set[ph]);
				write_reg(REG_STACKS, st_set[ph]);
				if (ph == 3)
					write_reg(2'd3, 24'hFFFFFF);
			end
			// the receiver holds off long enough for the pipeline to fill and stall input
			if (ph == 2)
				hold_until = cycles + 300;
			if (ph == 6)
				quiet = 1;
			add_random(100);
			drain();
		end

		if (errors == 0)
			$display("uv_sphere_vertex_generator_tb OK");
		else
			$display("uv_sphere_vertex_generator_tb NOT OK");
		$finish;
	end

endmodule

[filelist.f]
hdl/uvsph_pkg.sv
hdl/uvsph_trig.sv
hdl/uv_sphere_vertex_generator.sv
sim/uv_sphere_vertex_generator_tb.sv
